// ===== src/assert_macros.svh =====
// assertion macros shared by the sampler rtl
// expects signals named clock and reset in the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge outside reset
`define CBTS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// consequent holds in the cycle after the trigger
`define CBTS_ASSERT_NEXT(lbl, trig, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) else $error(msg);

`endif

// ===== src/cbts_pkg.sv =====
// shared types and constants of the bezier tangent sampler
// no dependencies
`default_nettype none

package cbts_pkg;

   localparam int COORD_BITS = 12;
   localparam int FRAC_BITS  = 8;
   localparam int STEP_BITS  = 6;
   localparam int LEN_BITS   = 8;
   localparam int CURVE_BITS = COORD_BITS + FRAC_BITS;
   localparam int END_BITS   = CURVE_BITS + 2;

   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 8;
   localparam logic [CSR_IDX_BITS-1:0] CSR_NUM_STEPS     = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_NORMAL_LENGTH = 2'd1;
   localparam logic [STEP_BITS-1:0]    NUM_STEPS_RESET     = 6'd63;
   localparam logic [LEN_BITS-1:0]     NORMAL_LENGTH_RESET = 8'd60;

   localparam int DIV_NUM_BITS = 48;
   localparam int DIV_DEN_BITS = 32;
   localparam int DIV_Q_BITS   = 20;
   localparam int ROOT_IN_BITS  = 64;
   localparam int ROOT_OUT_BITS = 32;

   typedef struct packed {
      logic [COORD_BITS-1:0] y;
      logic [COORD_BITS-1:0] x;
   } point_type;

   typedef struct packed {
      point_type p3;
      point_type p2;
      point_type p1;
      point_type p0;
   } segment_type;

   typedef struct packed {
      logic        push;
      segment_type seg;
   } queue_push_type;

   typedef struct packed {
      logic        valid;
      logic        full;
      segment_type seg;
   } queue_head_type;

   typedef struct packed {
      logic                    start;
      logic [DIV_NUM_BITS-1:0] num;
      logic [DIV_DEN_BITS-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic [DIV_Q_BITS-1:0] quot;
   } div_rsp_type;

   typedef struct packed {
      logic                    start;
      logic [ROOT_IN_BITS-1:0] radicand;
   } root_req_type;

   typedef struct packed {
      logic                     done;
      logic [ROOT_OUT_BITS-1:0] root;
   } root_rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_COEF, ST_COEF2, ST_MAC, ST_DIV_CX, ST_WAIT_CX, ST_DIV_CY,
      ST_WAIT_CY, ST_NORM, ST_SQ_X, ST_SQ_Y, ST_ROOT, ST_WAIT_ROOT, ST_MUL_X,
      ST_DIV_OX, ST_WAIT_OX, ST_MUL_Y, ST_DIV_OY, ST_WAIT_OY, ST_EMIT
   } back_state_type;

endpackage

`default_nettype wire

// ===== src/cbts_ifs.sv =====
// valid/ready channel interfaces of the sampler
// depends on cbts_pkg
`default_nettype none

interface cbts_req_if;
   logic                            valid;
   logic                            ready;
   logic [cbts_pkg::COORD_BITS-1:0] point_x;
   logic [cbts_pkg::COORD_BITS-1:0] point_y;
   modport source (output valid, point_x, point_y, input ready);
   modport sink   (input valid, point_x, point_y, output ready);
endinterface

interface cbts_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic        [cbts_pkg::CURVE_BITS-1:0] curve_x;
   logic        [cbts_pkg::CURVE_BITS-1:0] curve_y;
   logic signed [cbts_pkg::END_BITS-1:0]   normal_end_x;
   logic signed [cbts_pkg::END_BITS-1:0]   normal_end_y;
   logic                                 normal_valid;
   logic                                 last;
   modport source (output valid, curve_x, curve_y, normal_end_x, normal_end_y,
                   normal_valid, last, input ready);
   modport sink   (input valid, curve_x, curve_y, normal_end_x, normal_end_y,
                   normal_valid, last, output ready);
endinterface

interface cbts_csr_if;
   logic                               valid;
   logic                               ready;
   logic [cbts_pkg::CSR_IDX_BITS-1:0]  index;
   logic [cbts_pkg::CSR_DATA_BITS-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== src/cbts_front.sv =====
// front end: takes control points and forms complete cubic segments
// depends on cbts_pkg and cbts_ifs
`default_nettype none

module cbts_front (
   input  wire                      clock,
   input  wire                      reset,
   cbts_req_if.sink                 req,
   input  cbts_pkg::queue_head_type head,
   output cbts_pkg::queue_push_type push
);

   logic                have_first_ff, have_first_in;
   logic [1:0]          seen_ff, seen_in;
   cbts_pkg::point_type w0_ff, w0_in, w1_ff, w1_in, w2_ff, w2_in;
   cbts_pkg::point_type pt;
   logic                accept;

   assign req.ready = !head.full;
   assign accept    = req.valid && req.ready;
   assign pt.x      = req.point_x;
   assign pt.y      = req.point_y;

   assign push.push   = accept && have_first_ff && (seen_ff == 2'd2);
   assign push.seg.p0 = w0_ff;
   assign push.seg.p1 = w1_ff;
   assign push.seg.p2 = w2_ff;
   assign push.seg.p3 = pt;

   always_comb begin
      have_first_in = have_first_ff;
      seen_in       = seen_ff;
      w0_in         = w0_ff;
      w1_in         = w1_ff;
      w2_in         = w2_ff;
      if (accept) begin
         if (!have_first_ff) begin
            have_first_in = 1'b1;
            seen_in       = 2'd0;
            w0_in         = pt;
         end else begin
            case (seen_ff)
               2'd0: begin
                  w1_in   = pt;
                  seen_in = 2'd1;
               end
               2'd1: begin
                  w2_in   = pt;
                  seen_in = 2'd2;
               end
               default: begin
                  // end point opens the next segment
                  w0_in   = pt;
                  seen_in = 2'd0;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_first_ff <= 1'b0;
         seen_ff       <= 2'd0;
      end else begin
         have_first_ff <= have_first_in;
         seen_ff       <= seen_in;
      end
      w0_ff <= w0_in;
      w1_ff <= w1_in;
      w2_ff <= w2_in;
   end

endmodule

`default_nettype wire

// ===== src/cbts_queue.sv =====
// two-entry segment queue between front and back
// depends on cbts_pkg
`default_nettype none

module cbts_queue (
   input  wire                      clock,
   input  wire                      reset,
   input  cbts_pkg::queue_push_type push,
   input  wire                      pop,
   output cbts_pkg::queue_head_type head
);

   cbts_pkg::segment_type ent_ff [2];
   logic                  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0]            count_ff, count_in;

   assign head.valid = (count_ff != 2'd0);
   assign head.full  = (count_ff == 2'd2);
   assign head.seg   = ent_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push.push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff;
      if (push.push && !pop) count_in = count_ff + 2'd1;
      else if (!push.push && pop) count_in = count_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push.push) ent_ff[wr_ptr_ff] <= push.seg;
   end

endmodule

`default_nettype wire

// ===== src/cbts_div.sv =====
// restoring divider, one quotient bit a cycle
// depends on cbts_pkg; quotient must fit DIV_Q_BITS
`default_nettype none

module cbts_div (
   input  wire                    clock,
   input  wire                    reset,
   input  cbts_pkg::div_req_type  req,
   output cbts_pkg::div_rsp_type  rsp
);

   localparam int DSH_BITS = cbts_pkg::DIV_DEN_BITS + cbts_pkg::DIV_Q_BITS - 1;
   localparam int CNT_BITS = $clog2(cbts_pkg::DIV_Q_BITS);
   localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(cbts_pkg::DIV_Q_BITS - 1);

   logic                                busy_ff, busy_in, done_ff, done_in;
   logic [CNT_BITS-1:0]                 cnt_ff, cnt_in;
   logic [cbts_pkg::DIV_NUM_BITS-1:0]   rem_ff, rem_in;
   logic [DSH_BITS-1:0]                 dsh_ff, dsh_in;
   logic [cbts_pkg::DIV_Q_BITS-1:0]     quot_ff, quot_in;
   logic [DSH_BITS-1:0]                 rem_ext, diff;
   logic                                ge;

   assign rem_ext  = DSH_BITS'(rem_ff);
   assign ge       = (rem_ext >= dsh_ff);
   assign diff     = rem_ext - dsh_ff;
   assign rsp.done = done_ff;
   assign rsp.quot = quot_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quot_in = quot_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = req.num;
         dsh_in  = {req.den, {(cbts_pkg::DIV_Q_BITS-1){1'b0}}};
         quot_in = '0;
      end else if (busy_ff) begin
         if (ge) rem_in = diff[cbts_pkg::DIV_NUM_BITS-1:0];
         quot_in = {quot_ff[cbts_pkg::DIV_Q_BITS-2:0], ge};
         dsh_in  = dsh_ff >> 1;
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      quot_ff <= quot_in;
   end

endmodule

`default_nettype wire

// ===== src/cbts_sqrt.sv =====
// integer square root, one result bit a cycle
// depends on cbts_pkg
`default_nettype none

module cbts_sqrt (
   input  wire                     clock,
   input  wire                     reset,
   input  cbts_pkg::root_req_type  req,
   output cbts_pkg::root_rsp_type  rsp
);

   localparam int W        = cbts_pkg::ROOT_IN_BITS;
   localparam int CNT_BITS = $clog2(cbts_pkg::ROOT_OUT_BITS);
   localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(cbts_pkg::ROOT_OUT_BITS - 1);

   logic                busy_ff, busy_in, done_ff, done_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [W-1:0]        v_ff, v_in, r_ff, r_in, bit_ff, bit_in;
   logic [W-1:0]        trial;

   assign trial    = r_ff + bit_ff;
   assign rsp.done = done_ff;
   assign rsp.root = r_ff[cbts_pkg::ROOT_OUT_BITS-1:0];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      v_in    = v_ff;
      r_in    = r_ff;
      bit_in  = bit_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         v_in    = req.radicand;
         r_in    = '0;
         bit_in  = {2'b01, {(W-2){1'b0}}};
      end else if (busy_ff) begin
         if (v_ff >= trial) begin
            v_in = v_ff - trial;
            r_in = (r_ff >> 1) + bit_ff;
         end else begin
            r_in = r_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      v_ff   <= v_in;
      r_ff   <= r_in;
      bit_ff <= bit_in;
   end

endmodule

`default_nettype wire

// ===== src/cbts_back.sv =====
// back end: samples one segment at a time and drives the result register
// depends on cbts_pkg, cbts_ifs, cbts_div, cbts_sqrt, assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module cbts_back (
   input  wire                            clock,
   input  wire                            reset,
   input  cbts_pkg::queue_head_type       head,
   output logic                           pop,
   input  wire [cbts_pkg::STEP_BITS-1:0]  num_steps,
   input  wire [cbts_pkg::LEN_BITS-1:0]   normal_length,
   cbts_rsp_if.source                     rsp
);

   localparam int CB = cbts_pkg::COORD_BITS;
   localparam int SB = cbts_pkg::STEP_BITS;
   localparam int FB = cbts_pkg::FRAC_BITS;
   localparam int OB = cbts_pkg::CURVE_BITS;
   localparam int EB = cbts_pkg::END_BITS;
   localparam int CUBE_BITS = 3 * SB;
   localparam int ACC_BITS  = CUBE_BITS + CB;
   localparam int DC_BITS   = 2 * SB + 1;
   localparam int D_BITS    = DC_BITS + CB + 2;
   localparam int MAG_BITS  = 31;
   localparam int K_BITS    = cbts_pkg::LEN_BITS + FB;
   localparam int OFF_BITS  = K_BITS + 1;

   cbts_pkg::back_state_type state_ff, state_in;

   logic [SB-1:0]          j_ff, j_in, n_eff, u;
   cbts_pkg::point_type    pts_ff [4], pts_in [4];
   logic [CUBE_BITS-1:0]   c_ff [4], c_in [4];
   logic [DC_BITS-1:0]     d_ff [3], d_in [3];
   logic [1:0]             k_ff, k_in;
   logic [CUBE_BITS-1:0]   cube_ff, cube_in;
   logic [2*SB-1:0]        uu_ff, uu_in, jj_ff, jj_in, uj_ff, uj_in, nn;
   logic [ACC_BITS-1:0]    accx_ff, accx_in, accy_ff, accy_in;
   logic signed [D_BITS-1:0] dx_ff, dx_in, dy_ff, dy_in, prod_x, prod_y;
   logic signed [CB:0]     diff_x, diff_y;
   logic [D_BITS-1:0]      mag_x, mag_y;
   logic [OB-1:0]          cx_ff, cx_in, cy_ff, cy_in;
   logic [MAG_BITS-1:0]    ax_ff, ax_in, ay_ff, ay_in, mx;
   logic                   negx_ff, negx_in, negy_ff, negy_in, zero_d;
   logic [2*MAG_BITS-1:0]  sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic [cbts_pkg::ROOT_OUT_BITS-1:0] root_ff, root_in;
   logic [K_BITS+MAG_BITS-1:0] kp_ff, kp_in;
   logic [OFF_BITS-1:0]    offx_ff, offx_in, offy_ff, offy_in;
   logic [K_BITS-1:0]      kval;
   logic [63:0]            mul_p;
   logic [31:0]            mul_a, mul_b;
   logic                   out_free, out_load, last_sample;

   logic                   rv_ff, rv_in, nv_ff, nv_in, last_ff, last_in;
   logic [OB-1:0]          ocx_ff, ocx_in, ocy_ff, ocy_in;
   logic signed [EB-1:0]   oex_ff, oex_in, oey_ff, oey_in;

   cbts_pkg::div_req_type  div_req;
   cbts_pkg::div_rsp_type  div_rsp;
   cbts_pkg::root_req_type root_req;
   cbts_pkg::root_rsp_type root_rsp;

   cbts_div u_div (.clock(clock), .reset(reset), .req(div_req), .rsp(div_rsp));
   cbts_sqrt u_sqrt (.clock(clock), .reset(reset), .req(root_req), .rsp(root_rsp));

   // num_steps of zero runs as one interval
   assign n_eff       = (num_steps == '0) ? SB'(1) : num_steps;
   assign u           = n_eff - j_ff;
   assign nn          = n_eff * n_eff;
   assign kval        = {normal_length, {FB{1'b0}}};
   assign zero_d      = (dx_ff == '0) && (dy_ff == '0);
   assign mx          = (ax_ff > ay_ff) ? ax_ff : ay_ff;
   assign out_free    = !rv_ff || rsp.ready;
   assign last_sample = (j_ff == n_eff);
   assign mul_p       = mul_a * mul_b;

   assign diff_x = $signed({1'b0, pts_ff[1].x}) - $signed({1'b0, pts_ff[0].x});
   assign diff_y = $signed({1'b0, pts_ff[1].y}) - $signed({1'b0, pts_ff[0].y});
   assign prod_x = D_BITS'($signed({1'b0, d_ff[0]}) * diff_x);
   assign prod_y = D_BITS'($signed({1'b0, d_ff[0]}) * diff_y);
   assign mag_x  = dx_ff[D_BITS-1] ? D_BITS'(-dx_ff) : D_BITS'(dx_ff);
   assign mag_y  = dy_ff[D_BITS-1] ? D_BITS'(-dy_ff) : D_BITS'(dy_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cbts_pkg::ST_IDLE:      if (head.valid) state_in = cbts_pkg::ST_COEF;
         cbts_pkg::ST_COEF:      state_in = cbts_pkg::ST_COEF2;
         cbts_pkg::ST_COEF2:     state_in = cbts_pkg::ST_MAC;
         cbts_pkg::ST_MAC:       if (k_ff == 2'd3) state_in = cbts_pkg::ST_DIV_CX;
         cbts_pkg::ST_DIV_CX:    state_in = cbts_pkg::ST_WAIT_CX;
         cbts_pkg::ST_WAIT_CX:   if (div_rsp.done) state_in = cbts_pkg::ST_DIV_CY;
         cbts_pkg::ST_DIV_CY:    state_in = cbts_pkg::ST_WAIT_CY;
         cbts_pkg::ST_WAIT_CY: begin
            if (div_rsp.done) state_in = zero_d ? cbts_pkg::ST_EMIT : cbts_pkg::ST_NORM;
         end
         cbts_pkg::ST_NORM:      if (mx[MAG_BITS-1]) state_in = cbts_pkg::ST_SQ_X;
         cbts_pkg::ST_SQ_X:      state_in = cbts_pkg::ST_SQ_Y;
         cbts_pkg::ST_SQ_Y:      state_in = cbts_pkg::ST_ROOT;
         cbts_pkg::ST_ROOT:      state_in = cbts_pkg::ST_WAIT_ROOT;
         cbts_pkg::ST_WAIT_ROOT: if (root_rsp.done) state_in = cbts_pkg::ST_MUL_X;
         cbts_pkg::ST_MUL_X:     state_in = cbts_pkg::ST_DIV_OX;
         cbts_pkg::ST_DIV_OX:    state_in = cbts_pkg::ST_WAIT_OX;
         cbts_pkg::ST_WAIT_OX:   if (div_rsp.done) state_in = cbts_pkg::ST_MUL_Y;
         cbts_pkg::ST_MUL_Y:     state_in = cbts_pkg::ST_DIV_OY;
         cbts_pkg::ST_DIV_OY:    state_in = cbts_pkg::ST_WAIT_OY;
         cbts_pkg::ST_WAIT_OY:   if (div_rsp.done) state_in = cbts_pkg::ST_EMIT;
         cbts_pkg::ST_EMIT: begin
            if (out_free) state_in = last_sample ? cbts_pkg::ST_IDLE : cbts_pkg::ST_COEF;
         end
         default:                state_in = cbts_pkg::ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      pop               = 1'b0;
      out_load          = 1'b0;
      div_req.start     = 1'b0;
      div_req.num       = '0;
      div_req.den       = '0;
      root_req.start    = 1'b0;
      root_req.radicand = 64'(sqx_ff) + 64'(sqy_ff);
      mul_a             = 32'(ax_ff);
      mul_b             = 32'(ax_ff);
      case (state_ff)
         cbts_pkg::ST_IDLE:  pop = head.valid;
         cbts_pkg::ST_DIV_CX, cbts_pkg::ST_DIV_CY: begin
            div_req.start = 1'b1;
            div_req.den   = cbts_pkg::DIV_DEN_BITS'(cube_ff);
            div_req.num   = cbts_pkg::DIV_NUM_BITS'(
                               {(state_ff == cbts_pkg::ST_DIV_CX) ? accx_ff : accy_ff,
                                {FB{1'b0}}}) + cbts_pkg::DIV_NUM_BITS'(cube_ff >> 1);
         end
         cbts_pkg::ST_DIV_OX, cbts_pkg::ST_DIV_OY: begin
            div_req.start = 1'b1;
            div_req.den   = root_ff;
            div_req.num   = cbts_pkg::DIV_NUM_BITS'(kp_ff)
                          + cbts_pkg::DIV_NUM_BITS'(root_ff >> 1);
         end
         cbts_pkg::ST_SQ_Y: begin
            mul_a = 32'(ay_ff);
            mul_b = 32'(ay_ff);
         end
         cbts_pkg::ST_ROOT:  root_req.start = 1'b1;
         cbts_pkg::ST_MUL_X: begin
            mul_a = 32'(kval);
            mul_b = 32'(ax_ff);
         end
         cbts_pkg::ST_MUL_Y: begin
            mul_a = 32'(kval);
            mul_b = 32'(ay_ff);
         end
         cbts_pkg::ST_EMIT:  out_load = out_free;
         default: ;
      endcase
   end

   // datapath next values
   always_comb begin
      j_in    = j_ff;
      pts_in  = pts_ff;
      c_in    = c_ff;
      d_in    = d_ff;
      k_in    = k_ff;
      cube_in = cube_ff;
      uu_in   = uu_ff;
      jj_in   = jj_ff;
      uj_in   = uj_ff;
      accx_in = accx_ff;
      accy_in = accy_ff;
      dx_in   = dx_ff;
      dy_in   = dy_ff;
      cx_in   = cx_ff;
      cy_in   = cy_ff;
      ax_in   = ax_ff;
      ay_in   = ay_ff;
      negx_in = negx_ff;
      negy_in = negy_ff;
      sqx_in  = sqx_ff;
      sqy_in  = sqy_ff;
      root_in = root_ff;
      kp_in   = kp_ff;
      offx_in = offx_ff;
      offy_in = offy_ff;
      case (state_ff)
         cbts_pkg::ST_IDLE: begin
            j_in      = '0;
            pts_in[0] = head.seg.p0;
            pts_in[1] = head.seg.p1;
            pts_in[2] = head.seg.p2;
            pts_in[3] = head.seg.p3;
         end
         cbts_pkg::ST_COEF: begin
            uu_in   = u * u;
            jj_in   = j_ff * j_ff;
            uj_in   = u * j_ff;
            cube_in = nn * n_eff;
         end
         cbts_pkg::ST_COEF2: begin
            c_in[0] = uu_ff * u;
            c_in[1] = CUBE_BITS'(3) * (uu_ff * j_ff);
            c_in[2] = CUBE_BITS'(3) * (jj_ff * u);
            c_in[3] = jj_ff * j_ff;
            d_in[0] = DC_BITS'(uu_ff);
            d_in[1] = {uj_ff, 1'b0};
            d_in[2] = DC_BITS'(jj_ff);
            k_in    = 2'd0;
            accx_in = '0;
            accy_in = '0;
            dx_in   = '0;
            dy_in   = '0;
         end
         cbts_pkg::ST_MAC: begin
            // one control point per cycle; points and weights rotate past tap 0
            accx_in = accx_ff + ACC_BITS'(c_ff[0] * pts_ff[0].x);
            accy_in = accy_ff + ACC_BITS'(c_ff[0] * pts_ff[0].y);
            if (k_ff != 2'd3) begin
               dx_in = dx_ff + prod_x;
               dy_in = dy_ff + prod_y;
            end
            pts_in[0] = pts_ff[1];
            pts_in[1] = pts_ff[2];
            pts_in[2] = pts_ff[3];
            pts_in[3] = pts_ff[0];
            c_in[0]   = c_ff[1];
            c_in[1]   = c_ff[2];
            c_in[2]   = c_ff[3];
            c_in[3]   = c_ff[0];
            d_in[0]   = d_ff[1];
            d_in[1]   = d_ff[2];
            k_in      = k_ff + 2'd1;
         end
         cbts_pkg::ST_DIV_CX: begin
            ax_in   = MAG_BITS'(mag_x);
            ay_in   = MAG_BITS'(mag_y);
            negx_in = dx_ff[D_BITS-1];
            negy_in = dy_ff[D_BITS-1];
            offx_in = '0;
            offy_in = '0;
         end
         cbts_pkg::ST_WAIT_CX: if (div_rsp.done) cx_in = OB'(div_rsp.quot);
         cbts_pkg::ST_WAIT_CY: if (div_rsp.done) cy_in = OB'(div_rsp.quot);
         cbts_pkg::ST_NORM: begin
            // scale both components up until the larger reaches bit 30
            if (!mx[MAG_BITS-1]) begin
               if (mx[MAG_BITS-1:MAG_BITS-5] == '0) begin
                  ax_in = ax_ff << 4;
                  ay_in = ay_ff << 4;
               end else begin
                  ax_in = ax_ff << 1;
                  ay_in = ay_ff << 1;
               end
            end
         end
         cbts_pkg::ST_SQ_X:      sqx_in = mul_p[2*MAG_BITS-1:0];
         cbts_pkg::ST_SQ_Y:      sqy_in = mul_p[2*MAG_BITS-1:0];
         cbts_pkg::ST_WAIT_ROOT: if (root_rsp.done) root_in = root_rsp.root;
         cbts_pkg::ST_MUL_X, cbts_pkg::ST_MUL_Y: kp_in = mul_p[K_BITS+MAG_BITS-1:0];
         cbts_pkg::ST_WAIT_OX:   if (div_rsp.done) offx_in = OFF_BITS'(div_rsp.quot);
         cbts_pkg::ST_WAIT_OY:   if (div_rsp.done) offy_in = OFF_BITS'(div_rsp.quot);
         cbts_pkg::ST_EMIT:      if (out_free) j_in = j_ff + SB'(1);
         default: ;
      endcase
   end

   // result register
   always_comb begin
      rv_in   = rv_ff && !rsp.ready;
      ocx_in  = ocx_ff;
      ocy_in  = ocy_ff;
      oex_in  = oex_ff;
      oey_in  = oey_ff;
      nv_in   = nv_ff;
      last_in = last_ff;
      if (out_load) begin
         rv_in   = 1'b1;
         ocx_in  = cx_ff;
         ocy_in  = cy_ff;
         nv_in   = !zero_d;
         last_in = last_sample;
         // tangent turned by +90 degrees: end = curve + (-ty, tx)
         oex_in  = negy_ff ? $signed(EB'(cx_ff)) + $signed(EB'(offy_ff))
                           : $signed(EB'(cx_ff)) - $signed(EB'(offy_ff));
         oey_in  = negx_ff ? $signed(EB'(cy_ff)) - $signed(EB'(offx_ff))
                           : $signed(EB'(cy_ff)) + $signed(EB'(offx_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cbts_pkg::ST_IDLE;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
      end
      j_ff    <= j_in;
      pts_ff  <= pts_in;
      c_ff    <= c_in;
      d_ff    <= d_in;
      k_ff    <= k_in;
      cube_ff <= cube_in;
      uu_ff   <= uu_in;
      jj_ff   <= jj_in;
      uj_ff   <= uj_in;
      accx_ff <= accx_in;
      accy_ff <= accy_in;
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      cx_ff   <= cx_in;
      cy_ff   <= cy_in;
      ax_ff   <= ax_in;
      ay_ff   <= ay_in;
      negx_ff <= negx_in;
      negy_ff <= negy_in;
      sqx_ff  <= sqx_in;
      sqy_ff  <= sqy_in;
      root_ff <= root_in;
      kp_ff   <= kp_in;
      offx_ff <= offx_in;
      offy_ff <= offy_in;
      ocx_ff  <= ocx_in;
      ocy_ff  <= ocy_in;
      oex_ff  <= oex_in;
      oey_ff  <= oey_in;
      nv_ff   <= nv_in;
      last_ff <= last_in;
   end

   assign rsp.valid        = rv_ff;
   assign rsp.curve_x      = ocx_ff;
   assign rsp.curve_y      = ocy_ff;
   assign rsp.normal_end_x = oex_ff;
   assign rsp.normal_end_y = oey_ff;
   assign rsp.normal_valid = nv_ff;
   assign rsp.last         = last_ff;

   `CBTS_ASSERT_NEXT(a_last_ends_segment, out_load && last_sample, state_ff == cbts_pkg::ST_IDLE, "segment did not end after last sample")
   `CBTS_ASSERT(a_flat_end_on_curve, (rv_ff && !nv_ff) |-> ((oex_ff == $signed(EB'(ocx_ff))) && (oey_ff == $signed(EB'(ocy_ff)))), "normal end off curve for zero tangent")
   `CBTS_ASSERT(a_step_in_range, (state_ff != cbts_pkg::ST_IDLE) |-> (j_ff <= n_eff), "sample index beyond num_steps")

endmodule

`default_nettype wire

// ===== src/cubic_bezier_tangent_sampler_unit.sv =====
// Cubic bezier sampler: control points come in one per transfer; the first opens
// the chain and every three more complete a segment that shares its start with the
// previous end. Each completed segment gives num_steps+1 results (two when num_steps
// is zero; curve point and normal end, last set on t = 1). The back end handles one
// sample at a time with a shared 20-step divider used four times (twice when the
// tangent is zero) and a 32-step square root; a two-entry segment queue lets points
// keep arriving meanwhile. Registers: index 0 num_steps, index 1 normal_length;
// write them idle. Depends on cbts_pkg, cbts_ifs, cbts_front, cbts_queue, cbts_back.
`default_nettype none

module cubic_bezier_tangent_sampler_unit (
   input  wire          clock,
   input  wire          reset,
   cbts_req_if.sink     req_ch,
   cbts_rsp_if.source   rsp_ch,
   cbts_csr_if.sink     csr_ch
);

   logic [cbts_pkg::STEP_BITS-1:0] num_steps_ff, num_steps_in;
   logic [cbts_pkg::LEN_BITS-1:0]  normal_length_ff, normal_length_in;
   cbts_pkg::queue_push_type       push;
   cbts_pkg::queue_head_type       head;
   logic                           pop;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      num_steps_in     = num_steps_ff;
      normal_length_in = normal_length_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            cbts_pkg::CSR_NUM_STEPS:     num_steps_in = csr_ch.data[cbts_pkg::STEP_BITS-1:0];
            cbts_pkg::CSR_NORMAL_LENGTH: normal_length_in = csr_ch.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_steps_ff     <= cbts_pkg::NUM_STEPS_RESET;
         normal_length_ff <= cbts_pkg::NORMAL_LENGTH_RESET;
      end else begin
         num_steps_ff     <= num_steps_in;
         normal_length_ff <= normal_length_in;
      end
   end

   cbts_front u_front (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .head  (head),
      .push  (push)
   );

   cbts_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head)
   );

   cbts_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .pop           (pop),
      .num_steps     (num_steps_ff),
      .normal_length (normal_length_ff),
      .rsp           (rsp_ch)
   );

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// self-checking testbench for cubic_bezier_tangent_sampler_unit: directed corner segments,
// then random point chains over several register settings with random stalls on both sides
// depends on cbts_pkg, cbts_ifs and the sampler rtl
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [cbts_pkg::CSR_IDX_BITS-1:0] CSR_SPARE = 2'd3;
   localparam logic [cbts_pkg::COORD_BITS-1:0]   MAX_COORD = '1;

   typedef struct packed {
      logic [cbts_pkg::CURVE_BITS-1:0] curve_x;
      logic [cbts_pkg::CURVE_BITS-1:0] curve_y;
      logic [cbts_pkg::END_BITS-1:0]   end_x;
      logic [cbts_pkg::END_BITS-1:0]   end_y;
      logic                            normal_valid;
      logic                            last;
   } sample_type;

   class bezier_scoreboard;
      logic [cbts_pkg::STEP_BITS-1:0] steps;
      logic [cbts_pkg::LEN_BITS-1:0]  length;
      cbts_pkg::point_type            window[4];
      int                             seen;
      bit                             have_first;
      sample_type                     samples_due[$];
      int                             mismatches, points, results, segments;

      function new();
         steps = cbts_pkg::NUM_STEPS_RESET;
         length = cbts_pkg::NORMAL_LENGTH_RESET;
         foreach (window[k]) window[k] = '0;
         seen = 0;
         have_first = 0;
         mismatches = 0; points = 0; results = 0; segments = 0;
      endfunction

      function void note_config(logic [cbts_pkg::CSR_IDX_BITS-1:0] idx,
                                logic [cbts_pkg::CSR_DATA_BITS-1:0] data);
         if (idx == cbts_pkg::CSR_NUM_STEPS) steps = data[cbts_pkg::STEP_BITS-1:0];
         else if (idx == cbts_pkg::CSR_NORMAL_LENGTH) length = data[cbts_pkg::LEN_BITS-1:0];
      endfunction

      function longint unsigned int_sqrt(longint unsigned v);
         longint unsigned r, b;
         r = 0;
         b = 64'h4000_0000_0000_0000;
         while (b > v) b >>= 2;
         while (b != 0) begin
            if (v >= r + b) begin
               v -= r + b;
               r = (r >> 1) + b;
            end else r >>= 1;
            b >>= 2;
         end
         return r;
      endfunction

      function longint unsigned blend(longint unsigned a, b, c, d, u, j, n);
         longint unsigned cube, num;
         cube = n * n * n;
         num = u*u*u*a + 3*u*u*j*b + 3*u*j*j*c + j*j*j*d;
         return ((num << cbts_pkg::FRAC_BITS) + cube / 2) / cube;
      endfunction

      function longint slope(longint a, b, c, d, u, j);
         return u*u*(b - a) + 2*u*j*(c - b) + j*j*(d - c);
      endfunction

      function void sample_segment();
         longint unsigned n, u, cx, cy, ax, ay, mx, mag, k, offx, offy;
         longint dx, dy, ex, ey;
         sample_type s;
         n = (steps == 0) ? 1 : steps;
         for (longint unsigned j = 0; j <= n; j++) begin
            u = n - j;
            cx = blend(window[0].x, window[1].x, window[2].x, window[3].x, u, j, n);
            cy = blend(window[0].y, window[1].y, window[2].y, window[3].y, u, j, n);
            dx = slope(window[0].x, window[1].x, window[2].x, window[3].x, u, j);
            dy = slope(window[0].y, window[1].y, window[2].y, window[3].y, u, j);
            ex = cx;
            ey = cy;
            s.normal_valid = 0;
            if (dx != 0 || dy != 0) begin
               ax = dx < 0 ? -dx : dx;
               ay = dy < 0 ? -dy : dy;
               mx = ax > ay ? ax : ay;
               while (mx < (64'd1 << 30)) begin
                  ax <<= 1; ay <<= 1; mx <<= 1;
               end
               mag = int_sqrt(ax*ax + ay*ay);
               k = longint'(length) << cbts_pkg::FRAC_BITS;
               offx = (k*ax + mag/2) / mag;
               offy = (k*ay + mag/2) / mag;
               ex = dy < 0 ? ex + longint'(offy) : ex - longint'(offy);
               ey = dx < 0 ? ey - longint'(offx) : ey + longint'(offx);
               s.normal_valid = 1;
            end
            s.curve_x = cx[cbts_pkg::CURVE_BITS-1:0];
            s.curve_y = cy[cbts_pkg::CURVE_BITS-1:0];
            s.end_x = ex[cbts_pkg::END_BITS-1:0];
            s.end_y = ey[cbts_pkg::END_BITS-1:0];
            s.last = (j == n);
            samples_due = {samples_due, s};
         end
      endfunction

      function void note_point(logic [cbts_pkg::COORD_BITS-1:0] x,
                               logic [cbts_pkg::COORD_BITS-1:0] y);
         cbts_pkg::point_type p;
         p.x = x;
         p.y = y;
         points++;
         if (!have_first) begin
            window[0] = p;
            have_first = 1;
            seen = 0;
            return;
         end
         window[seen + 1] = p;
         seen++;
         if (seen < 3) return;
         sample_segment();
         segments++;
         window[0] = window[3];
         seen = 0;
      endfunction

      function void check_sample(sample_type got);
         sample_type want;
         results++;
         if (samples_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("tb: unexpected sample x=%h y=%h",
                                           got.curve_x, got.curve_y);
            return;
         end
         want = samples_due.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("tb: sample %0d want %h %h %h %h %b %b got %h %h %h %h %b %b",
                        results, want.curve_x, want.curve_y, want.end_x, want.end_y,
                        want.normal_valid, want.last, got.curve_x, got.curve_y,
                        got.end_x, got.end_y, got.normal_valid, got.last);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   bit   calm = 0;
   int   stall_left = 0;

   cbts_req_if req_ch();
   cbts_rsp_if rsp_ch();
   cbts_csr_if csr_ch();

   cubic_bezier_tangent_sampler_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source),
      .csr_ch (csr_ch.sink)
   );

   bezier_scoreboard sb = new();

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("tb: failure");
      $finish;
   end

   // receiver stalls in bursts until the calm stretch
   initial begin
      rsp_ch.ready = 0;
      forever begin
         @(negedge clock);
         if (calm) rsp_ch.ready = 1;
         else if (stall_left > 0) begin
            rsp_ch.ready = 0;
            stall_left--;
         end else if ($urandom_range(0, 4) == 0) begin
            rsp_ch.ready = 0;
            stall_left = $urandom_range(0, 10);
         end else rsp_ch.ready = 1;
      end
   end

   initial begin
      sample_type got;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            got.curve_x = rsp_ch.curve_x;
            got.curve_y = rsp_ch.curve_y;
            got.end_x = rsp_ch.normal_end_x;
            got.end_y = rsp_ch.normal_end_y;
            got.normal_valid = rsp_ch.normal_valid;
            got.last = rsp_ch.last;
            sb.check_sample(got);
         end
      end
   end

   task automatic send_point(input logic [cbts_pkg::COORD_BITS-1:0] x,
                             input logic [cbts_pkg::COORD_BITS-1:0] y);
      int gap;
      gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid = 0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid = 1;
      req_ch.point_x = x;
      req_ch.point_y = y;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_point(x, y);
   endtask

   task automatic write_reg(input logic [cbts_pkg::CSR_IDX_BITS-1:0] idx,
                            input logic [cbts_pkg::CSR_DATA_BITS-1:0] data);
      @(negedge clock);
      req_ch.valid = 0;
      csr_ch.valid = 1;
      csr_ch.index = idx;
      csr_ch.data = data;
      do @(posedge clock); while (!csr_ch.ready);
      sb.note_config(idx, data);
      @(negedge clock);
      csr_ch.valid = 0;
   endtask

   // drain all samples, then give the back end time to settle
   task automatic drain();
      @(negedge clock);
      req_ch.valid = 0;
      while (sb.samples_due.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   function automatic logic [cbts_pkg::COORD_BITS-1:0] pick_coord(
         logic [cbts_pkg::COORD_BITS-1:0] prev);
      case ($urandom_range(0, 9))
         0: return '0;
         1: return MAX_COORD;
         2: return prev;
         default: return cbts_pkg::COORD_BITS'($urandom_range(0, MAX_COORD));
      endcase
   endfunction

   initial begin
      logic [cbts_pkg::COORD_BITS-1:0]    lx, ly;
      logic [cbts_pkg::CSR_DATA_BITS-1:0] steps_val, len_val;
      req_ch.valid = 0;
      req_ch.point_x = '0;
      req_ch.point_y = '0;
      csr_ch.valid = 0;
      csr_ch.index = '0;
      csr_ch.data = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // reset settings: full-range corners, then a degenerate segment
      send_point('0, '0);
      send_point(MAX_COORD, MAX_COORD);
      send_point('0, MAX_COORD);
      send_point(MAX_COORD, '0);
      repeat (3) send_point(MAX_COORD, '0);
      drain();

      // spare index is ignored; steps of zero act as one; zero length
      write_reg(CSR_SPARE, 8'hFF);
      write_reg(cbts_pkg::CSR_NUM_STEPS, 8'h00);
      write_reg(cbts_pkg::CSR_NORMAL_LENGTH, 8'h00);
      send_point(12'd12, 12'd4000);
      send_point(12'd12, 12'd4000);
      send_point(12'd3000, 12'd7);
      drain();

      // high data bits dropped on num_steps; longest normal
      write_reg(cbts_pkg::CSR_NUM_STEPS, 8'hC1);
      write_reg(cbts_pkg::CSR_NORMAL_LENGTH, 8'hFF);
      send_point(12'd2048, 12'd2048);
      send_point(12'd2048, 12'd2048);
      send_point(12'd2049, 12'd2049);
      send_point(12'd1, 12'd4094);
      send_point(12'd4094, 12'd1);
      send_point(12'd2730, 12'd1365);
      drain();

      lx = '0;
      ly = '0;
      for (int ph = 0; ph < 6; ph++) begin
         steps_val = cbts_pkg::CSR_DATA_BITS'($urandom_range(2, 12));
         if (ph == 0) steps_val = 8'd63;
         else if (ph == 1) steps_val = 8'd1;
         len_val = cbts_pkg::CSR_DATA_BITS'($urandom_range(0, 255));
         if (ph == 2) len_val = 8'd0;
         else if (ph == 3) len_val = 8'd255;
         write_reg(cbts_pkg::CSR_NUM_STEPS, steps_val);
         write_reg(cbts_pkg::CSR_NORMAL_LENGTH, len_val);
         if (ph == 5) calm = 1;
         repeat (16) begin
            lx = pick_coord(lx);
            ly = pick_coord(ly);
            send_point(lx, ly);
         end
         drain();
      end

      $display("tb: %0d points sent, %0d segments, %0d samples checked, %0d mismatches",
               sb.points, sb.segments, sb.results, sb.mismatches);
      if (sb.mismatches == 0 && sb.samples_due.size() == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end
endmodule

`default_nettype wire
